// ===== rtl/core/kmsd_pkg.sv =====
// Shared constants and types for the key matrix scanner with debounce.
package kmsd_pkg;

  localparam int ROW_COUNT      = 7;
  localparam int COLUMN_SELECTS = 8;
  localparam int MAX_PRESSED    = 8;
  localparam int RESULT_CAP     = 8;

  localparam int KEY_COUNT = ROW_COUNT * COLUMN_SELECTS;
  localparam int SCAN_W    = 56;
  localparam int MAP_W     = 28;
  localparam int NIBBLE_W  = 4;
  localparam int MAP_ROWS  = MAP_W / NIBBLE_W;
  localparam int COL_W     = 3;
  localparam int ROW_W     = 3;
  localparam int CNT_W     = $clog2(KEY_COUNT + 1);
  localparam int CAP_W     = $clog2(RESULT_CAP);
  localparam int X_W       = 4;
  localparam int Y_W       = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // column groups of four share one x map register
  localparam int COL_GROUP = 4;
  localparam logic [Y_W-1:0] Y_TOP = Y_W'(3);

  // register select, taken from paddr[2]
  localparam logic REG_X_MAP_LOW  = 1'b0;
  localparam logic REG_X_MAP_HIGH = 1'b1;

  typedef logic [KEY_COUNT-1:0] key_mask_t;
  typedef logic [MAP_W-1:0]     x_map_t;

endpackage

// ===== rtl/core/key_matrix_scan_debounce.sv =====
// Key matrix scanner: two-scan debounce and serial key report.
// A scan is accepted into an input register and evaluated in the next cycle against the
// previous scan and the stable set; a scan that changes the stable set loads the report
// serializer, which places each result in the result register. A report has one result
// per pressed key (at most eight) or a single none_pressed result, emitted one per cycle
// by the report serializer while no result is stalled. Scans that do not change the
// stable set flow through at one per cycle even while a report is being emitted; a scan
// that changes the stable set waits in the input register until the serializer has
// loaded the last result of the previous report into the result register.
module key_matrix_scan_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [kmsd_pkg::DATA_W-1:0]   pwdata,
  output logic [kmsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          scan_valid_i,
  output logic                          scan_ready_o,
  input  logic [kmsd_pkg::SCAN_W-1:0]   scan_levels_i,
  output logic                          key_valid_o,
  input  logic                          key_ready_i,
  output logic [kmsd_pkg::X_W-1:0]      key_x_o,
  output logic [kmsd_pkg::Y_W-1:0]      key_y_o,
  output logic                          none_pressed_o,
  output logic                          last_key_o
);
  import kmsd_pkg::*;

  x_map_t              x_map_low_q, x_map_high_q;
  logic                in_valid_q;
  logic [SCAN_W-1:0]   levels_q;
  key_mask_t           prev_q, stable_q, rep_q;
  logic                busy_q, rep_none_q;
  logic [CAP_W-1:0]    emit_cnt_q;
  logic                out_valid_q, out_none_q, out_last_q;
  logic [X_W-1:0]      out_x_q;
  logic [Y_W-1:0]      out_y_q;

  key_mask_t           cur;
  logic                changed, advance, emit, ser_last;
  key_mask_t           rest;
  logic [COL_W-1:0]    sel_col;
  logic [ROW_W-1:0]    sel_row;
  x_map_t              sel_map;
  logic [X_W-1:0]      sel_x;
  logic [Y_W-1:0]      sel_y;
  logic                cfg_wr;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_X_MAP_HIGH) ? DATA_W'(x_map_high_q) : DATA_W'(x_map_low_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_map_low_q  <= '0;
      x_map_high_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_X_MAP_LOW) begin
        x_map_low_q <= pwdata[MAP_W-1:0];
      end else begin
        x_map_high_q <= pwdata[MAP_W-1:0];
      end
    end
  end

  // pressed set, first MAX_PRESSED keys in column-major order
  always_comb begin
    key_mask_t            pressed;
    logic [ROW_COUNT-1:0] col_bits;
    logic [CNT_W-1:0]     col_base;
    logic [CNT_W-1:0]     below;
    pressed  = ~levels_q[KEY_COUNT-1:0];
    cur      = '0;
    col_base = '0;
    for (int c = 0; c < COLUMN_SELECTS; c++) begin
      col_bits = pressed[c*ROW_COUNT +: ROW_COUNT];
      for (int r = 0; r < ROW_COUNT; r++) begin
        below = col_base + CNT_W'($countones(col_bits & ROW_COUNT'((1 << r) - 1)));
        if (col_bits[r] && (below < CNT_W'(MAX_PRESSED))) begin
          cur[c*ROW_COUNT + r] = 1'b1;
        end
      end
      col_base = col_base + CNT_W'($countones(col_bits));
    end
  end

  assign changed      = (cur == prev_q) && (cur != stable_q);
  assign advance      = in_valid_q && (!changed || !busy_q);
  assign scan_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (scan_ready_o) begin
      in_valid_q <= scan_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_ready_o && scan_valid_i) begin
      levels_q <= scan_levels_i;
    end
  end

  // lowest pressed key of the pending report
  always_comb begin
    logic [ROW_COUNT-1:0] col_bits;
    sel_col = '0;
    sel_row = '0;
    for (int c = COLUMN_SELECTS - 1; c >= 0; c--) begin
      if (|rep_q[c*ROW_COUNT +: ROW_COUNT]) begin
        sel_col = COL_W'(c);
      end
    end
    col_bits = rep_q[int'(sel_col)*ROW_COUNT +: ROW_COUNT];
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (col_bits[r]) begin
        sel_row = ROW_W'(r);
      end
    end
  end

  assign rest    = rep_q & (rep_q - KEY_COUNT'(1));
  assign sel_map = (sel_col >= COL_W'(COL_GROUP)) ? x_map_high_q : x_map_low_q;
  assign sel_x   = (int'(sel_row) < MAP_ROWS) ? sel_map[int'(sel_row)*NIBBLE_W +: NIBBLE_W]
                                              : '0;
  assign sel_y   = Y_TOP - sel_col[Y_W-1:0];

  assign emit     = busy_q && (!out_valid_q || key_ready_i);
  assign ser_last = rep_none_q || (rest == '0) || (emit_cnt_q == CAP_W'(RESULT_CAP - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      stable_q   <= '0;
      rep_q      <= '0;
      busy_q     <= 1'b0;
      rep_none_q <= 1'b0;
      emit_cnt_q <= '0;
    end else begin
      if (advance) begin
        prev_q <= cur;
        if (changed) begin
          stable_q   <= cur;
          rep_q      <= cur;
          rep_none_q <= (cur == '0);
          busy_q     <= 1'b1;
          emit_cnt_q <= '0;
        end
      end
      if (emit) begin
        if (ser_last) begin
          busy_q <= 1'b0;
        end else begin
          rep_q      <= rest;
          emit_cnt_q <= emit_cnt_q + CAP_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (key_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q    <= rep_none_q ? '0 : sel_x;
      out_y_q    <= rep_none_q ? '0 : sel_y;
      out_none_q <= rep_none_q;
      out_last_q <= ser_last;
    end
  end

  assign key_valid_o    = out_valid_q;
  assign key_x_o        = out_x_q;
  assign key_y_o        = out_y_q;
  assign none_pressed_o = out_none_q;
  assign last_key_o     = out_last_q;

endmodule

// ===== rtl/core/kmsd_checker.sv =====
// Port-level checks for the key matrix scanner, bound to the top level.
module kmsd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        key_valid_o,
  input logic                        key_ready_i,
  input logic [kmsd_pkg::X_W-1:0]    key_x_o,
  input logic [kmsd_pkg::Y_W-1:0]    key_y_o,
  input logic                        none_pressed_o,
  input logic                        last_key_o
);
  import kmsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && !key_ready_i |=> key_valid_o && $stable(key_x_o) && $stable(key_y_o)
      && $stable(none_pressed_o) && $stable(last_key_o))
    else $error("result changed while stalled");

  // an empty-set report is a single result
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && none_pressed_o |-> last_key_o)
    else $error("none_pressed result not marked last");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && none_pressed_o |-> key_x_o == '0 && key_y_o == '0)
    else $error("none_pressed result carries a coordinate");

  // results of one report follow without gaps
  a_report_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && key_ready_i && !last_key_o |=> key_valid_o)
    else $error("gap inside a key report");

endmodule

bind key_matrix_scan_debounce kmsd_checker u_kmsd_checker (.*);
